>>> src/ssom_pkg.sv
// ----------------------------------------------------------------------------
// ssom_pkg
// Shared sizes, codes and types of the spectrum slot occupancy map.
// ----------------------------------------------------------------------------
package ssom_pkg;

  // Store geometry: link, then core, then slot.
  localparam int MAX_SLOTS   = 512;
  localparam int MAX_CORES   = 8;
  localparam int MAX_LINKS   = 32;
  localparam int STORE_DEPTH = MAX_LINKS * MAX_CORES * MAX_SLOTS;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);

  // Field widths of the words on the two channels.
  localparam int KIND_W   = 2;
  localparam int LINK_W   = 5;
  localparam int CORE_W   = 3;
  localparam int SLOT_W   = 9;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 16;

  // Configuration register widths.
  localparam int SLOTS_REG_W = 10;
  localparam int CORES_REG_W = 4;
  localparam int LINKS_REG_W = 6;

  // APB port.
  localparam int PADDR_W = 4;
  localparam int PDATA_W = 32;

  typedef enum logic [KIND_W-1:0] {
    KIND_ALLOC    = 2'd0,
    KIND_RELEASE  = 2'd1,
    KIND_QUERY    = 2'd2,
    KIND_RESERVED = 2'd3
  } kind_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 2'd0,
    ST_RANGE    = 2'd1,
    ST_CONFLICT = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    REG_SLOTS = 2'd0,
    REG_CORES = 2'd1,
    REG_LINKS = 2'd2
  } reg_idx_t;

  // One store entry: occupied bit and saturating use counter.
  typedef struct packed {
    logic               occ;
    logic [COUNT_W-1:0] count;
  } entry_t;

endpackage

>>> src/ssom_in_if.sv
// ----------------------------------------------------------------------------
// ssom_in_if
// Request channel: one allocate, release or query word per handshake.
// ----------------------------------------------------------------------------
interface ssom_in_if;
  import ssom_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [KIND_W-1:0]    kind;
  logic [LINK_W-1:0]    link_index;
  logic [CORE_W-1:0]    core_index;
  logic [SLOT_W-1:0]    first_slot;
  logic [SLOT_W-1:0]    last_slot;

  modport source (output valid, kind, link_index, core_index, first_slot, last_slot,
                  input ready);
  modport sink   (input valid, kind, link_index, core_index, first_slot, last_slot,
                  output ready);
endinterface

>>> src/ssom_out_if.sv
// ----------------------------------------------------------------------------
// ssom_out_if
// Result channel: one status word per request.
// ----------------------------------------------------------------------------
interface ssom_out_if;
  import ssom_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [STATUS_W-1:0]  status;
  logic                 slot_taken;
  logic [COUNT_W-1:0]   use_count;

  modport source (output valid, status, slot_taken, use_count, input ready);
  modport sink   (input valid, status, slot_taken, use_count, output ready);
endinterface

>>> src/spectrum_slot_occupancy_map_unit.sv
// ----------------------------------------------------------------------------
// spectrum_slot_occupancy_map_unit
// Occupied bit and 16-bit use counter per slot, per core, per link.
// ----------------------------------------------------------------------------
// After reset the block sweeps its store to zero, one entry per cycle, over
// all STORE_DEPTH (131072) entries; req.ready stays low during the sweep, while
// APB writes are taken as ever. It then handles one request word at a time.
// An allocate or release of n slots reads, modifies and writes back one
// slot per cycle through the single-port-pair store. A word passes through
// acceptance, the walk over the range, a drain step for the last write back
// and a step to load the result. A query walks its single slot the same way;
// a rejected word, an empty range or the reserved kind goes from acceptance
// straight to loading the result. The result sits in an output register, so
// the next word is taken while a result waits; a finished word waits only
// if the previous result has not yet been taken. Indices at or above the
// configured limits reject the whole word with a range status; a taken slot
// on allocate or a free slot on release is skipped and flagged with a
// conflict status. Counters saturate at 65535.
// ----------------------------------------------------------------------------
module spectrum_slot_occupancy_map_unit (
  input  logic                          clk,
  input  logic                          rst,
  ssom_in_if.sink                       req,
  ssom_out_if.source                    rsp,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [ssom_pkg::PADDR_W-1:0]  paddr,
  input  logic [ssom_pkg::PDATA_W-1:0]  pwdata,
  output logic [ssom_pkg::PDATA_W-1:0]  prdata,
  output logic                          pready
);
  import ssom_pkg::*;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_WALK,
    S_DRAIN,
    S_RESP
  } state_t;

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [SLOTS_REG_W-1:0] slots_in_use;
  logic [CORES_REG_W-1:0] cores_in_use;
  logic [LINKS_REG_W-1:0] links_in_use;
  logic                   cfg_wr;
  reg_idx_t               cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cfg_idx = reg_idx_t'(paddr[3:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      slots_in_use <= SLOTS_REG_W'(MAX_SLOTS);
      cores_in_use <= CORES_REG_W'(MAX_CORES);
      links_in_use <= LINKS_REG_W'(MAX_LINKS);
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_SLOTS: slots_in_use <= pwdata[SLOTS_REG_W-1:0];
        REG_CORES: cores_in_use <= pwdata[CORES_REG_W-1:0];
        REG_LINKS: links_in_use <= pwdata[LINKS_REG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_SLOTS: prdata = PDATA_W'(slots_in_use);
      REG_CORES: prdata = PDATA_W'(cores_in_use);
      REG_LINKS: prdata = PDATA_W'(links_in_use);
      default:   prdata = '0;
    endcase
  end

  // Clamp each limit to the store geometry.
  logic [SLOTS_REG_W-1:0] lim_s;
  logic [CORES_REG_W-1:0] lim_c;
  logic [LINKS_REG_W-1:0] lim_l;

  assign lim_s = (slots_in_use > SLOTS_REG_W'(MAX_SLOTS)) ? SLOTS_REG_W'(MAX_SLOTS)
                                                          : slots_in_use;
  assign lim_c = (cores_in_use > CORES_REG_W'(MAX_CORES)) ? CORES_REG_W'(MAX_CORES)
                                                          : cores_in_use;
  assign lim_l = (links_in_use > LINKS_REG_W'(MAX_LINKS)) ? LINKS_REG_W'(MAX_LINKS)
                                                          : links_in_use;

  // --------------------------------------------------------------------------
  // Request decode (looked at only in the accept cycle)
  // --------------------------------------------------------------------------
  kind_t             in_kind;
  logic              in_range;
  logic              in_empty;
  logic [ADDR_W-1:0] in_base;
  logic              req_fire;

  assign in_kind  = kind_t'(req.kind);
  assign in_empty = req.last_slot < req.first_slot;

  always_comb begin
    in_range = (LINKS_REG_W'(req.link_index) < lim_l) &&
               (CORES_REG_W'(req.core_index) < lim_c) &&
               (SLOTS_REG_W'(req.first_slot) < lim_s);
    if ((in_kind == KIND_ALLOC || in_kind == KIND_RELEASE) && !in_empty &&
        (SLOTS_REG_W'(req.last_slot) >= lim_s)) begin
      in_range = 1'b0;
    end
  end

  // Row base of the addressed link and core.
  assign in_base = (ADDR_W'(req.link_index) * ADDR_W'(MAX_CORES) + ADDR_W'(req.core_index))
                   * ADDR_W'(MAX_SLOTS);

  // --------------------------------------------------------------------------
  // Store: one write port, one registered read port
  // --------------------------------------------------------------------------
  entry_t            mem [STORE_DEPTH];
  logic              mem_we;
  logic [ADDR_W-1:0] mem_wa;
  entry_t            mem_wd;
  logic [ADDR_W-1:0] mem_ra;
  entry_t            rd_data;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    rd_data <= mem[mem_ra];
  end

  // --------------------------------------------------------------------------
  // Sequencer
  // --------------------------------------------------------------------------
  state_t              state;
  logic [ADDR_W-1:0]   clr_addr;
  kind_t               kind_q;
  logic [ADDR_W-1:0]   base;
  logic [SLOT_W-1:0]   cur;
  logic [SLOT_W-1:0]   last_q;
  logic                rd_pend;
  logic [ADDR_W-1:0]   rd_addr;
  logic [STATUS_W-1:0] status_q;
  logic                taken_q;
  logic [COUNT_W-1:0]  count_q;
  logic                rsp_free;
  logic                rmw_conflict;

  assign req.ready = (state == S_IDLE);
  assign req_fire  = req.valid && req.ready;
  assign rsp_free  = !rsp.valid || rsp.ready;
  assign mem_ra    = base + ADDR_W'(cur);

  // Modify the entry that came back from the store.
  always_comb begin
    mem_we       = 1'b0;
    mem_wa       = rd_addr;
    mem_wd       = rd_data;
    rmw_conflict = 1'b0;
    if (state == S_CLEAR) begin
      mem_we = 1'b1;
      mem_wa = clr_addr;
      mem_wd = '0;
    end else if (rd_pend) begin
      case (kind_q)
        KIND_ALLOC: begin
          if (rd_data.occ) begin
            rmw_conflict = 1'b1;
          end else begin
            mem_we       = 1'b1;
            mem_wd.occ   = 1'b1;
            mem_wd.count = (rd_data.count == '1) ? rd_data.count
                                                 : rd_data.count + COUNT_W'(1);
          end
        end
        KIND_RELEASE: begin
          if (!rd_data.occ) begin
            rmw_conflict = 1'b1;
          end else begin
            mem_we     = 1'b1;
            mem_wd.occ = 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_addr  <= '0;
      rd_pend   <= 1'b0;
      rsp.valid <= 1'b0;
    end else begin
      // Load a finished result when the output register is free, else drop
      // the result once taken.
      if (state == S_RESP && rsp_free) begin
        rsp.valid <= 1'b1;
      end else if (rsp.valid && rsp.ready) begin
        rsp.valid <= 1'b0;
      end

      // Fold the returning read into the word's outcome.
      if (rd_pend) begin
        if (rmw_conflict) begin
          status_q <= ST_CONFLICT;
        end
        if (kind_q == KIND_QUERY) begin
          taken_q <= rd_data.occ;
          count_q <= rd_data.count;
        end
      end
      // Each walk step issues one read whose data comes back next cycle.
      rd_pend <= (state == S_WALK);

      unique case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + ADDR_W'(1);
          if (clr_addr == ADDR_W'(STORE_DEPTH - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (req_fire) begin
            kind_q   <= in_kind;
            base     <= in_base;
            cur      <= req.first_slot;
            last_q   <= (in_kind == KIND_QUERY) ? req.first_slot : req.last_slot;
            taken_q  <= 1'b0;
            count_q  <= '0;
            status_q <= ST_OK;
            if (in_kind == KIND_RESERVED) begin
              state <= S_RESP;
            end else if (!in_range) begin
              status_q <= ST_RANGE;
              state    <= S_RESP;
            end else if (in_kind != KIND_QUERY && in_empty) begin
              state <= S_RESP;
            end else begin
              state <= S_WALK;
            end
          end
        end
        S_WALK: begin
          // Issue one read per slot; the write back lands in the following cycle.
          rd_addr <= mem_ra;
          if (cur == last_q) begin
            state <= S_DRAIN;
          end else begin
            cur <= cur + SLOT_W'(1);
          end
        end
        S_DRAIN: begin
          state <= S_RESP;
        end
        S_RESP: begin
          // Hold until the output register is free.
          if (rsp_free) begin
            rsp.status     <= status_q;
            rsp.slot_taken <= taken_q;
            rsp.use_count  <= count_q;
            state          <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  // A write back never targets the entry read in the same cycle of a walk.
  a_no_rw_overlap: assert property (@(posedge clk) disable iff (rst)
    (mem_we && state == S_WALK) |-> (mem_wa != mem_ra))
    else $error("write back overlaps read in walk");

  // Read data is expected only in the cycle after a walk step.
  a_rd_after_walk: assert property (@(posedge clk) disable iff (rst)
    rd_pend |-> ($past(state) == S_WALK))
    else $error("read pending outside walk");

  // Only a successful query carries slot data.
  a_no_stray_data: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.status != ST_OK) |-> (!rsp.slot_taken && rsp.use_count == '0))
    else $error("failed word carries slot data");

  // No word is taken while the store is being swept.
  a_no_req_in_clear: assert property (@(posedge clk) disable iff (rst)
    (state == S_CLEAR) |=> !$past(req_fire))
    else $error("request taken during sweep");

endmodule
